// ----- rtl/core/ssd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, field widths and segment tables of the scan display controller.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int unsigned OPCODE_W   = 2;
    localparam int unsigned POSITION_W = 3;
    localparam int unsigned VALUE_W    = 8;
    localparam int unsigned NUMBER_W   = 32;
    localparam int unsigned SEGMENT_W  = 8;
    localparam int unsigned SELECT_W   = 3;
    localparam int unsigned BITCNT_W   = $clog2(NUMBER_W);
    localparam int unsigned DIVISOR_W  = 8;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic SCAN_ENABLE_RST              = 1'b1;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RST  = 8'd4;

    localparam logic [SEGMENT_W-1:0] SEG_BLANK = 8'h00;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK   = 2'd0,
        OP_RAW    = 2'd1,
        OP_CHAR   = 2'd2,
        OP_NUMBER = 2'd3
    } t_opcode;

    // register index, taken from paddr bit 2
    typedef enum logic {
        REG_SCAN_ENABLE  = 1'b0,
        REG_SCAN_DIVISOR = 1'b1
    } t_reg_index;

    // decimal digit to segments
    function automatic logic [SEGMENT_W-1:0] digit_code(input logic [3:0] d);
        logic [SEGMENT_W-1:0] seg;
        case (d)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // ascii character to segments, unknown characters blank
    function automatic logic [SEGMENT_W-1:0] encode_char(input logic [VALUE_W-1:0] c);
        logic [SEGMENT_W-1:0] seg;
        case (c)
            8'h30:   seg = 8'h3F;
            8'h31:   seg = 8'h06;
            8'h32:   seg = 8'h5B;
            8'h33:   seg = 8'h4F;
            8'h34:   seg = 8'h66;
            8'h35:   seg = 8'h6D;
            8'h36:   seg = 8'h7D;
            8'h37:   seg = 8'h07;
            8'h38:   seg = 8'h7F;
            8'h39:   seg = 8'h6F;
            8'h41:   seg = 8'h77;
            8'h42:   seg = 8'h7C;
            8'h43:   seg = 8'h39;
            8'h44:   seg = 8'h5E;
            8'h45:   seg = 8'h79;
            8'h46:   seg = 8'h71;
            8'h48:   seg = 8'h76;
            8'h4C:   seg = 8'h38;
            8'h50:   seg = 8'h73;
            8'h55:   seg = 8'h3E;
            8'h6E:   seg = 8'h54;
            8'h6F:   seg = 8'h5C;
            8'h79:   seg = 8'h6E;
            8'h68:   seg = 8'h74;
            8'h72:   seg = 8'h50;
            8'h74:   seg = 8'h78;
            8'h2D:   seg = 8'h40;
            8'h2E:   seg = 8'h80;
            8'h21:   seg = 8'hF9;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/core/ssd_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_in_if
// Command channel of the scan display controller with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssd_in_if
    import ssd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [POSITION_W-1:0] position;
    logic [VALUE_W-1:0]    value;
    logic [NUMBER_W-1:0]   number;

    modport source (output valid, output opcode, output position, output value,
                    output number, input ready);
    modport sink   (input valid, input opcode, input position, input value,
                    input number, output ready);
endinterface

// ----- rtl/core/ssd_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_out_if
// Result channel of the scan display controller with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssd_out_if
    import ssd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [SEGMENT_W-1:0] segment_drive;
    logic [SELECT_W-1:0]  digit_select;
    logic                 scanned;

    modport source (output valid, output segment_drive, output digit_select,
                    output scanned, input ready);
    modport sink   (input valid, input segment_drive, input digit_select,
                    input scanned, output ready);
endinterface

// ----- rtl/core/seven_segment_scan_display.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_display
// Multiplexed seven-segment display controller with display buffer.
//
// Commands arrive on i_in (tick, raw segment write, character write, number
// display); every accepted transaction gives one result transaction on o_out
// carrying the driven segments, the selected digit and a scanned flag.
// Tick, raw and character writes complete in the accept cycle; the result is
// registered and shows in the next cycle. A number display reports its result
// at once, then converts the value bit-serially through a BCD shift register,
// one binary bit per cycle, and writes the buffer in the ST_WRITE state: i_in
// is held off through ST_CONV and ST_WRITE after a number display.
// Other commands sustain one transaction per cycle while o_out keeps up.
// If the receiver stalls, the result stays in the output register and i_in
// drops ready until the result is taken.
// Reset blanks the buffer, clears the scan state, enables scanning and sets the
// divisor to 4. The APB port holds scan_enable at 0x0 and scan_divisor at 0x4;
// the user must write it only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module seven_segment_scan_display
    import ssd_pkg::*;
#(
    parameter int unsigned DIGITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssd_in_if.sink                i_in,
    ssd_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int unsigned BCD_W = 4 * DIGITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CONV  = 3'b010,
        ST_WRITE = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_scan_enable;
    logic [DIVISOR_W-1:0]   r_scan_divisor;
    logic [SEGMENT_W-1:0]   r_buffer [DIGITS];
    logic [DIVISOR_W-1:0]   r_prescale, n_prescale;
    logic [DIG_W-1:0]       r_next_digit, n_next_digit;
    logic [SEGMENT_W-1:0]   r_seg_latch, n_seg_latch;
    logic [SELECT_W-1:0]    r_sel_latch, n_sel_latch;
    logic                   n_scanned;

    logic                   r_ovalid;
    logic [SEGMENT_W-1:0]   r_oseg;
    logic [SELECT_W-1:0]    r_osel;
    logic                   r_oscan;

    logic [NUMBER_W-1:0]    r_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [BITCNT_W-1:0]    r_bitcnt;
    logic                   r_ovf;

    logic                   in_acc;
    logic                   out_free;
    logic                   cfg_wr;
    logic                   pos_ok;
    logic [DIVISOR_W-1:0]   pre_inc;
    logic [BCD_W-1:0]       bcd_adj;
    logic [SEGMENT_W-1:0]   num_seg [DIGITS];
    t_opcode                op;

    assign op       = t_opcode'(i_in.opcode);
    assign out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;
    assign in_acc   = i_in.valid && i_in.ready;
    assign pos_ok   = {1'b0, i_in.position} < (POSITION_W + 1)'(DIGITS);

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        unique case (t_reg_index'(paddr[2]))
            REG_SCAN_ENABLE:  prdata = {{(APB_DATA_W-1){1'b0}}, r_scan_enable};
            REG_SCAN_DIVISOR: prdata = {{(APB_DATA_W-DIVISOR_W){1'b0}}, r_scan_divisor};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_enable  <= SCAN_ENABLE_RST;
            r_scan_divisor <= DIVISOR_RST;
        end else if (cfg_wr) begin
            unique case (t_reg_index'(paddr[2]))
                REG_SCAN_ENABLE:  r_scan_enable  <= pwdata[0];
                REG_SCAN_DIVISOR: r_scan_divisor <= pwdata[DIVISOR_W-1:0];
                default: ;
            endcase
        end
    end

    // tick handling
    assign pre_inc = r_prescale + DIVISOR_W'(1);

    always_comb begin
        n_prescale   = r_prescale;
        n_next_digit = r_next_digit;
        n_seg_latch  = r_seg_latch;
        n_sel_latch  = r_sel_latch;
        n_scanned    = 1'b0;
        if (in_acc && op == OP_TICK && r_scan_enable) begin
            if (pre_inc < r_scan_divisor) begin
                n_prescale = pre_inc;
            end else begin
                n_prescale  = '0;
                n_scanned   = 1'b1;
                n_sel_latch = SELECT_W'(r_next_digit);
                n_seg_latch = r_buffer[r_next_digit];
                if (r_next_digit == DIG_W'(DIGITS - 1)) begin
                    n_next_digit = '0;
                end else begin
                    n_next_digit = r_next_digit + DIG_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale   <= '0;
            r_next_digit <= '0;
            r_seg_latch  <= '0;
            r_sel_latch  <= '0;
        end else begin
            r_prescale   <= n_prescale;
            r_next_digit <= n_next_digit;
            r_seg_latch  <= n_seg_latch;
            r_sel_latch  <= n_sel_latch;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (in_acc) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_oseg  <= n_seg_latch;
            r_osel  <= n_sel_latch;
            r_oscan <= n_scanned;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.segment_drive = r_oseg;
    assign o_out.digit_select  = r_osel;
    assign o_out.scanned       = r_oscan;

    // binary to bcd, one bit per cycle, add-3 on every digit
    always_comb begin
        bcd_adj = r_bcd;
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                bcd_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end
        end
    end

    // leading zero digits stay blank unless overflowed; the ones digit always shows
    always_comb begin
        logic seen;
        seen = r_ovf;
        for (int k = DIGITS - 1; k >= 0; k--) begin
            seen = seen || (r_bcd[4*k +: 4] != 4'd0) || (k == 0);
            num_seg[k] = seen ? digit_code(r_bcd[4*k +: 4]) : SEG_BLANK;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && op == OP_NUMBER) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_bitcnt == BITCNT_W'(NUMBER_W - 1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_bin    <= i_in.number;
            r_bcd    <= '0;
            r_bitcnt <= '0;
            r_ovf    <= 1'b0;
        end else if (r_state == ST_CONV) begin
            r_bin    <= {r_bin[NUMBER_W-2:0], 1'b0};
            r_bcd    <= {bcd_adj[BCD_W-2:0], r_bin[NUMBER_W-1]};
            r_bitcnt <= r_bitcnt + BITCNT_W'(1);
            r_ovf    <= r_ovf || bcd_adj[BCD_W-1];
        end
    end

    // display buffer, position 0 is the leftmost digit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < DIGITS; p++) begin
                r_buffer[p] <= SEG_BLANK;
            end
        end else if (r_state == ST_WRITE) begin
            for (int p = 0; p < DIGITS; p++) begin
                r_buffer[p] <= num_seg[DIGITS - 1 - p];
            end
        end else if (in_acc && pos_ok) begin
            if (op == OP_RAW) begin
                r_buffer[i_in.position[DIG_W-1:0]] <= i_in.value;
            end else if (op == OP_CHAR) begin
                r_buffer[i_in.position[DIG_W-1:0]] <= encode_char(i_in.value);
            end
        end
    end

    a_next_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_digit <= DIG_W'(DIGITS - 1))
        else $error("scan index beyond last digit");

    a_result_mirrors_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_oseg == r_seg_latch) && (r_osel == r_sel_latch))
        else $error("pending result differs from driven latches");

    a_number_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && op == OP_NUMBER) |=> r_state == ST_CONV)
        else $error("number display did not start conversion");

    a_conv_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_bitcnt == BITCNT_W'(NUMBER_W - 1)) |=> r_state == ST_WRITE)
        else $error("conversion did not end after last bit");

    a_scan_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sel_latch != $past(r_sel_latch)) |-> $past(in_acc && op == OP_TICK))
        else $error("select latch moved without a tick");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the seven-segment scan display controller.
// A short directed table is run first: scan after reset, extreme segment
// bytes, several character classes, zero, wide and plain numbers. Random commands
// follow under several scan settings and idle patterns. These include
// character string bursts and a long result hold-off. Every result
// transaction is checked against a cycle-free model of the display buffer
// and the scan latches, or against the expected result of a typed table row.
// ----------------------------------------------------------------------------
module tb;
    import ssd_pkg::*;

    localparam int unsigned HALF_PERIOD  = 2;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_ITEMS  = 175;
    localparam int unsigned TABLE_ROWS   = 25;
    localparam int unsigned NUM_DIGITS   = 8;

    localparam logic [SEGMENT_W-1:0] DEC_GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        t_opcode               op;
        logic [POSITION_W-1:0] pos;
        logic [VALUE_W-1:0]    val;
        logic [NUMBER_W-1:0]   num;
    } disp_cmd_t;

    typedef struct packed {
        logic [SEGMENT_W-1:0] seg;
        logic [SELECT_W-1:0]  sel;
        logic                 scanned;
    } scan_out_t;

    typedef struct packed {
        logic      typed;
        scan_out_t res;
    } typed_note_t;

    typedef struct packed {
        t_opcode               op;
        logic [POSITION_W-1:0] pos;
        logic [VALUE_W-1:0]    val;
        logic [NUMBER_W-1:0]   num;
        logic                  typed;
        scan_out_t             res;
    } table_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ssd_in_if  in_if ();
    ssd_out_if out_if ();

    seven_segment_scan_display uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state
    logic [SEGMENT_W-1:0] disp_buf [NUM_DIGITS];
    logic [DIVISOR_W-1:0] prescale;
    logic [SELECT_W-1:0]  digit_ptr;
    logic [SEGMENT_W-1:0] seg_latch;
    logic [SELECT_W-1:0]  sel_latch;
    logic                 scan_en;
    logic [DIVISOR_W-1:0] scan_div;

    scan_out_t   pending_drive_q [$];
    typed_note_t typed_drive_q [$];
    int unsigned mismatch_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_req;
    string       glyph_chars = "0123456789ABCDEFHLPUnoyhrt-.! ";

    table_row_t  dir_rows [TABLE_ROWS];

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [SEGMENT_W-1:0] glyph_of(input logic [VALUE_W-1:0] c);
        if (c >= "0" && c <= "9") begin
            return DEC_GLYPH[c - "0"];
        end
        case (c)
            "A": return 8'h77;
            "B": return 8'h7C;
            "C": return 8'h39;
            "D": return 8'h5E;
            "E": return 8'h79;
            "F": return 8'h71;
            "H": return 8'h76;
            "L": return 8'h38;
            "P": return 8'h73;
            "U": return 8'h3E;
            "n": return 8'h54;
            "o": return 8'h5C;
            "y": return 8'h6E;
            "h": return 8'h74;
            "r": return 8'h50;
            "t": return 8'h78;
            "-": return 8'h40;
            ".": return 8'h80;
            "!": return 8'hF9;
            default: return SEG_BLANK;
        endcase
    endfunction

    function automatic scan_out_t step_display(input disp_cmd_t c);
        logic                scanned;
        logic [NUMBER_W-1:0] n;
        int                  p;
        scanned = 1'b0;
        case (c.op)
            OP_TICK: begin
                if (scan_en) begin
                    prescale = prescale + 1'b1;
                    if (prescale >= scan_div) begin
                        prescale  = '0;
                        sel_latch = digit_ptr;
                        seg_latch = disp_buf[digit_ptr];
                        digit_ptr = digit_ptr + 1'b1;
                        scanned   = 1'b1;
                    end
                end
            end
            OP_RAW: disp_buf[c.pos] = c.val;
            OP_CHAR: disp_buf[c.pos] = glyph_of(c.val);
            default: begin
                n = c.num;
                for (p = 0; p < NUM_DIGITS; p++) disp_buf[p] = SEG_BLANK;
                if (n == 0) begin
                    disp_buf[NUM_DIGITS-1] = DEC_GLYPH[0];
                end
                p = NUM_DIGITS - 1;
                while (n != 0 && p >= 0) begin
                    disp_buf[p] = DEC_GLYPH[n % 10];
                    n = n / 10;
                    p--;
                end
            end
        endcase
        return '{seg_latch, sel_latch, scanned};
    endfunction

    function automatic logic [VALUE_W-1:0] pick_glyph_char();
        return glyph_chars[$urandom_range(glyph_chars.len() - 1)];
    endfunction

    function automatic disp_cmd_t random_cmd();
        disp_cmd_t   c;
        int unsigned pick;
        pick  = $urandom_range(99);
        c.pos = POSITION_W'($urandom_range(NUM_DIGITS - 1));
        c.val = VALUE_W'($urandom_range(255));
        c.num = $urandom;
        if (pick < 50) begin
            c.op = OP_TICK;
        end else if (pick < 65) begin
            c.op = OP_RAW;
        end else if (pick < 85) begin
            c.op = OP_CHAR;
            if ($urandom_range(3) != 0) c.val = pick_glyph_char();
        end else begin
            c.op = OP_NUMBER;
            case ($urandom_range(7))
                0: c.num = '0;
                1, 2: c.num = $urandom_range(99999);
                3: begin
                    c.num = 1;
                    repeat ($urandom_range(9)) c.num = c.num * 10;
                end
                default: c.num = $urandom;
            endcase
        end
        return c;
    endfunction

    // model update and result check, both on the same edge
    always @(posedge i_clk) begin : scoreboard
        disp_cmd_t   c;
        scan_out_t   want;
        scan_out_t   got;
        typed_note_t note;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_index'(paddr[2]))
                    REG_SCAN_ENABLE:  scan_en  = pwdata[0];
                    REG_SCAN_DIVISOR: scan_div = pwdata[DIVISOR_W-1:0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                c = '{t_opcode'(in_if.opcode), in_if.position, in_if.value, in_if.number};
                want = step_display(c);
                if (typed_drive_q.size() != 0) begin
                    note = typed_drive_q.pop_front();
                    if (note.typed) want = note.res;
                end
                pending_drive_q.push_back(want);
            end
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.segment_drive, out_if.digit_select, out_if.scanned};
                if (pending_drive_q.size() == 0) begin
                    $error("result transaction with none outstanding: %h %0d %0b",
                           got.seg, got.sel, got.scanned);
                    mismatch_count++;
                end else begin
                    want = pending_drive_q.pop_front();
                    if (got.seg !== want.seg) begin
                        $error("segment_drive: expected %h, got %h", want.seg, got.seg);
                        mismatch_count++;
                    end
                    if (got.sel !== want.sel) begin
                        $error("digit_select: expected %0d, got %0d", want.sel, got.sel);
                        mismatch_count++;
                    end
                    if (got.scanned !== want.scanned) begin
                        $error("scanned: expected %0b, got %0b", want.scanned, got.scanned);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // result side ready pattern and long hold-off
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic offer_cmd(input disp_cmd_t c, input logic typed, input scan_out_t res);
        typed_drive_q.push_back('{typed, res});
        in_if.valid    <= 1'b1;
        in_if.opcode   <= c.op;
        in_if.position <= c.pos;
        in_if.value    <= c.val;
        in_if.number   <= c.num;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_drive_q.size() != 0);
    endtask

    task automatic reg_write(input t_reg_index idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        #4ms;
        $display("seven_segment_scan_display test failed");
        $finish;
    end

    initial begin : stimulus
        logic                 ph_en  [PHASES];
        logic [DIVISOR_W-1:0] ph_div [PHASES];
        disp_cmd_t            c;
        int unsigned          burst_left;
        ph_en  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        ph_div = '{8'd1, 8'd255, 8'd3, 8'd3, 8'd0, 8'd2};
        dir_rows = '{
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b1, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b1, '{8'h00, 3'd0, 1'b1}},
            '{OP_RAW,    3'd0, 8'hFF, 32'd0, 1'b1, '{8'h00, 3'd0, 1'b0}},
            '{OP_RAW,    3'd7, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_CHAR,   3'd1, "0",   32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_CHAR,   3'd2, "!",   32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_CHAR,   3'd3, "-",   32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_CHAR,   3'd4, ".",   32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_CHAR,   3'd5, 8'hFF, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_CHAR,   3'd6, "y",   32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b1, '{8'h3F, 3'd1, 1'b1}},
            '{OP_NUMBER, 3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_NUMBER, 3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_NUMBER, 3'd0, 8'h00, 32'd100000000, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_NUMBER, 3'd0, 8'h00, 32'd12345, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_RAW,    3'd2, 8'h55, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}},
            '{OP_TICK,   3'd0, 8'h00, 32'd0, 1'b0, '{8'h00, 3'd0, 1'b0}}
        };

        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.opcode   = OP_TICK;
        in_if.position = '0;
        in_if.value    = '0;
        in_if.number   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        burst_left     = 0;
        send_idle_pct  = 36;
        recv_idle_pct  = 66;

        for (int i = 0; i < NUM_DIGITS; i++) disp_buf[i] = SEG_BLANK;
        prescale  = '0;
        digit_ptr = '0;
        seg_latch = '0;
        sel_latch = '0;
        scan_en   = SCAN_ENABLE_RST;
        scan_div  = DIVISOR_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < TABLE_ROWS; r++) begin
            c = '{dir_rows[r].op, dir_rows[r].pos, dir_rows[r].val, dir_rows[r].num};
            sender_gap();
            offer_cmd(c, dir_rows[r].typed, dir_rows[r].res);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            case (ph / 2)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            reg_write(REG_SCAN_ENABLE, {{(APB_DATA_W-1){1'b0}}, ph_en[ph]});
            reg_write(REG_SCAN_DIVISOR, {{(APB_DATA_W-DIVISOR_W){1'b0}}, ph_div[ph]});
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 60) hold_req = 1'b1;
                if (ph == 2 && k == 60) drain_results();
                if (burst_left == 0 && $urandom_range(99) < 6) burst_left = NUM_DIGITS;
                if (burst_left != 0) begin
                    c.op  = OP_CHAR;
                    c.pos = POSITION_W'(NUM_DIGITS - burst_left);
                    c.val = ($urandom_range(9) == 0) ? VALUE_W'($urandom_range(255))
                                                     : pick_glyph_char();
                    c.num = $urandom;
                    burst_left--;
                end else begin
                    c = random_cmd();
                end
                sender_gap();
                offer_cmd(c, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_drive_q.size() == 0) begin
            $display("seven_segment_scan_display test passed");
        end else begin
            $display("seven_segment_scan_display test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ssd_pkg.sv
rtl/core/ssd_in_if.sv
rtl/core/ssd_out_if.sv
rtl/core/seven_segment_scan_display.sv
bench/tb.sv
